FILE: rtl/core/lpct_pkg.sv
package lpct_pkg;

  localparam int Depth = 256;
  localparam int IdxW = 8;
  localparam int CntW = 9;
  localparam int StreamBits = 4;
  localparam int SectorsPerPage = 16;
  localparam int KeyW = StreamBits + 32;

  typedef enum logic [2:0] {
    REQ_PROBE = 3'd0,
    REQ_LOOKUP = 3'd1,
    REQ_INS_CLEAN = 3'd2,
    REQ_INS_DIRTY = 3'd3,
    REQ_UPDATE = 3'd4,
    REQ_MARK_WB = 3'd5,
    REQ_REMOVE = 3'd6,
    REQ_EVICT = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_MISS = 3'd1,
    ST_DUP = 3'd2,
    ST_FULL = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_CLEAN = 2'd1;
  localparam logic [1:0] SLOT_DIRTY = 2'd2;
  localparam logic [1:0] SLOT_WB = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RANK,
    S_READ,
    S_WAIT,
    S_DONE
  } fsm_t;

endpackage

FILE: rtl/core/lru_page_cache_table.sv
// Fully associative LRU page cache table. out_valid rises after the scan, rank,
// read and wait states; the result transfers when out_stall is low, and out_valid
// holds while out_stall stays high. After the transfer the block returns to idle,
// where it takes the next request. A first pass over all entries (registered
// memory read) finds the key, the least recent entry and the first free slot, a
// second pass walks the recency ranks through one shared compare/increment unit,
// then the entry payload is read from its memory. in_stall is high from acceptance
// until the result is transferred. capacity must be written only while idle; the
// block itself does not enforce this.
module lru_page_cache_table import lpct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [3:0]  stream_num,
  input  logic [31:0] page_number,
  input  logic [63:0] page_content,
  input  logic [63:0] data_time,
  input  logic [15:0] sector_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status_code,
  output logic        found,
  output logic [31:0] slot_page,
  output logic [15:0] slot_sectors,
  output logic [63:0] slot_content,
  output logic [63:0] slot_time,
  output logic [1:0]  slot_state,
  output logic [8:0]  occupancy
);

  fsm_t state, state_next;
  logic [CntW-1:0] capacity, count;
  req_t op;
  logic [KeyW-1:0] key;
  logic [63:0] content, tm;
  logic [15:0] sectors;
  logic [CntW-1:0] ptr;
  logic hit, lru_hit, free_hit;
  logic [IdxW-1:0] hit_idx, lru_idx, free_idx, ref_rank, tgt;
  logic [2:0] st;
  logic do_read;

  logic scan_valid;
  logic [KeyW-1:0] scan_key;
  logic [IdxW-1:0] scan_rank, rank_wdata;
  logic rank_we, valid_we, valid_wdata, data_we, key_we, state_we;
  logic [1:0] wr_state;
  logic [15:0] rd_sectors;
  logic [63:0] rd_content, rd_time;
  logic [1:0] rd_state;
  logic [31:0] rd_page;
  logic [IdxW-1:0] sidx, didx;
  logic dval;
  logic is_ins, is_evict, last;
  logic [CntW-1:0] cap_eff;

  // ptr is the read address; scan data of the previous address arrives in the next cycle
  assign sidx = ptr[IdxW-1:0];
  assign didx = IdxW'(ptr - 1'b1);
  assign dval = (ptr != '0);
  assign last = (ptr == CntW'(Depth));
  assign is_ins = (op == REQ_INS_CLEAN) || (op == REQ_INS_DIRTY);
  assign is_evict = (op == REQ_EVICT);
  assign cap_eff = (capacity > CntW'(Depth)) ? CntW'(Depth) : capacity;

  lpct_store u_store (
    .clk, .rst, .scan_idx(sidx), .scan_valid, .scan_key, .scan_rank,
    .rank_we, .rank_idx(didx), .rank_wdata, .valid_we, .wr_idx(tgt), .valid_wdata,
    .data_we, .key_we, .wr_key(key), .wr_sectors(sectors), .wr_content(content),
    .wr_time(tm), .state_we, .wr_state, .rd_idx(tgt), .rd_sectors,
    .rd_content, .rd_time, .rd_state, .rd_page
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (last) state_next = S_RANK;
      S_RANK: if (last) state_next = S_READ;
      S_READ: state_next = S_WAIT;
      S_WAIT: state_next = S_DONE;
      S_DONE: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Decide target and status at end of scan (combinational on scan results)
  logic go;  // operation modifies the table
  always_comb begin
    go = 1'b0;
    tgt = hit_idx;
    st = ST_OK;
    case (op) inside
      REQ_PROBE: st = hit ? ST_OK : ST_MISS;
      REQ_INS_CLEAN, REQ_INS_DIRTY: begin
        tgt = free_idx;
        if (hit) st = ST_DUP;
        else if (count >= cap_eff || !free_hit) st = ST_FULL;
        else go = 1'b1;
      end
      REQ_EVICT: begin
        tgt = lru_idx;
        if (count == '0 || !lru_hit) st = ST_EMPTY;
        else go = 1'b1;
      end
      default: begin
        if (!hit) st = ST_MISS;
        else go = 1'b1;
      end
    endcase
  end

  // Rank unit: one entry per cycle in second pass; the least recent entry
  // leaves on evict, so no other rank moves then
  always_comb begin
    rank_we = 1'b0;
    rank_wdata = scan_rank;
    if (state == S_RANK && go && dval) begin
      if (didx == tgt && (is_ins || op == REQ_LOOKUP || op == REQ_UPDATE)) begin
        rank_we = 1'b1;
        rank_wdata = '0;
      end else if (scan_valid) begin
        if ((is_ins || op == REQ_LOOKUP || op == REQ_UPDATE) &&
            (is_ins || scan_rank < ref_rank)) begin
          rank_we = 1'b1;
          rank_wdata = scan_rank + 1'b1;
        end else if (op == REQ_REMOVE && scan_rank > ref_rank) begin
          rank_we = 1'b1;
          rank_wdata = scan_rank - 1'b1;
        end
      end
    end
  end

  // Table writes at the wait step
  always_comb begin
    valid_we = 1'b0;
    valid_wdata = 1'b0;
    data_we = 1'b0;
    key_we = 1'b0;
    state_we = 1'b0;
    wr_state = SLOT_DIRTY;
    if (state == S_WAIT && go) begin
      case (op) inside
        REQ_INS_CLEAN, REQ_INS_DIRTY: begin
          valid_we = 1'b1;
          valid_wdata = 1'b1;
          data_we = 1'b1;
          key_we = 1'b1;
          state_we = 1'b1;
          wr_state = (op == REQ_INS_CLEAN) ? SLOT_CLEAN : SLOT_DIRTY;
        end
        REQ_UPDATE: begin
          data_we = 1'b1;
          state_we = 1'b1;
        end
        REQ_MARK_WB: begin
          state_we = 1'b1;
          wr_state = SLOT_WB;
        end
        REQ_REMOVE, REQ_EVICT: valid_we = 1'b1;
        default: ;
      endcase
    end
  end

  assign do_read = go && (op == REQ_LOOKUP || is_evict);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CntW'(256);
      count <= '0;
      ptr <= '0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      if (state == S_IDLE && in_valid) begin
        op <= req_t'(req_type);
        key <= {stream_num[StreamBits-1:0], page_number};
        content <= page_content;
        tm <= data_time;
        sectors <= sector_mask[SectorsPerPage-1:0];
        ptr <= '0;
        hit <= 1'b0;
        lru_hit <= 1'b0;
        free_hit <= 1'b0;
      end
      if (state == S_SCAN) begin
        ptr <= last ? '0 : ptr + 1'b1;
        if (dval && scan_valid && scan_key == key && !hit) begin
          hit <= 1'b1;
          hit_idx <= didx;
          ref_rank <= scan_rank;
        end
        if (dval && scan_valid && {1'b0, scan_rank} == count - 1'b1 && !lru_hit) begin
          lru_hit <= 1'b1;
          lru_idx <= didx;
        end
        if (dval && !scan_valid && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= didx;
        end
      end
      if (state == S_RANK) begin
        ptr <= ptr + 1'b1;
      end
      if (state == S_WAIT && go) begin
        if (is_ins) count <= count + 1'b1;
        else if (op == REQ_REMOVE || is_evict) count <= count - 1'b1;
      end
      if (state == S_WAIT) begin
        status_code <= st;
        found <= is_evict ? 1'b0 : hit;
        slot_page <= do_read ? rd_page : '0;
        slot_sectors <= do_read ? rd_sectors : '0;
        slot_content <= do_read ? rd_content : '0;
        slot_time <= do_read ? rd_time : '0;
        slot_state <= do_read ? rd_state : SLOT_EMPTY;
      end
    end
  end

  assign occupancy = count;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth)) else $error("occupancy overflow");
  a_ok_ins: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && is_ins && st == ST_OK) |=> count == $past(count) + 1'b1)
    else $error("insert did not grow table");

endmodule

FILE: rtl/core/lpct_store.sv
// Entry storage: payload RAM plus per-entry valid bits and recency ranks.
module lpct_store import lpct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IdxW-1:0]      scan_idx,
  output logic                 scan_valid,
  output logic [KeyW-1:0]      scan_key,
  output logic [IdxW-1:0]      scan_rank,
  input  logic                 rank_we,
  input  logic [IdxW-1:0]      rank_idx,
  input  logic [IdxW-1:0]      rank_wdata,
  input  logic                 valid_we,
  input  logic [IdxW-1:0]      wr_idx,
  input  logic                 valid_wdata,
  input  logic                 data_we,
  input  logic                 key_we,
  input  logic [KeyW-1:0]      wr_key,
  input  logic [15:0]          wr_sectors,
  input  logic [63:0]          wr_content,
  input  logic [63:0]          wr_time,
  input  logic                 state_we,
  input  logic [1:0]           wr_state,
  input  logic [IdxW-1:0]      rd_idx,
  output logic [15:0]          rd_sectors,
  output logic [63:0]          rd_content,
  output logic [63:0]          rd_time,
  output logic [1:0]           rd_state,
  output logic [31:0]          rd_page
);

  logic [Depth-1:0] valid;
  logic [KeyW-1:0] key_mem [Depth];
  logic [IdxW-1:0] rank_mem [Depth];
  logic [15:0] sec_mem [Depth];
  logic [63:0] con_mem [Depth];
  logic [63:0] tim_mem [Depth];
  logic [1:0] sta_mem [Depth];

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (valid_we) begin
      valid[wr_idx] <= valid_wdata;
    end
  end

  // Key and rank memories, registered scan read of one entry a cycle
  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_idx] <= wr_key;
    if (rank_we) rank_mem[rank_idx] <= rank_wdata;
    scan_valid <= valid[scan_idx];
    scan_key <= key_mem[scan_idx];
    scan_rank <= rank_mem[scan_idx];
  end

  // Payload memory, registered read
  always_ff @(posedge clk) begin
    if (data_we) begin
      sec_mem[wr_idx] <= wr_sectors;
      con_mem[wr_idx] <= wr_content;
      tim_mem[wr_idx] <= wr_time;
    end
    if (state_we) sta_mem[wr_idx] <= wr_state;
    rd_sectors <= sec_mem[rd_idx];
    rd_content <= con_mem[rd_idx];
    rd_time <= tim_mem[rd_idx];
    rd_state <= sta_mem[rd_idx];
    rd_page <= key_mem[rd_idx][31:0];
  end

endmodule

FILE: tb/lru_page_cache_table_test.sv
module lru_page_cache_table_test;
  import lpct_pkg::*;

  typedef struct packed {
    req_t        op;
    logic [3:0]  sid;
    logic [31:0] page;
    logic [63:0] content;
    logic [63:0] dtime;
    logic [15:0] mask;
  } page_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [31:0] page;
    logic [15:0] sectors;
    logic [63:0] content;
    logic [63:0] dtime;
    logic [1:0]  state;
    logic [8:0]  occ;
  } page_resp_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  req_type;
  logic [3:0]  stream_num;
  logic [31:0] page_number;
  logic [63:0] page_content;
  logic [63:0] data_time;
  logic [15:0] sector_mask;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status_code;
  logic        found;
  logic [31:0] slot_page;
  logic [15:0] slot_sectors;
  logic [63:0] slot_content;
  logic [63:0] slot_time;
  logic [1:0]  slot_state;
  logic [8:0]  occupancy;

  lru_page_cache_table i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .stream_num(stream_num), .page_number(page_number), .page_content(page_content),
    .data_time(data_time), .sector_mask(sector_mask), .out_valid(out_valid),
    .out_stall(out_stall), .status_code(status_code), .found(found),
    .slot_page(slot_page), .slot_sectors(slot_sectors), .slot_content(slot_content),
    .slot_time(slot_time), .slot_state(slot_state), .occupancy(occupancy)
  );

  // shadow table of the block
  logic        tbl_valid [Depth];
  logic [35:0] tbl_key [Depth];
  logic [15:0] tbl_sectors [Depth];
  logic [63:0] tbl_content [Depth];
  logic [63:0] tbl_time [Depth];
  logic [1:0]  tbl_state [Depth];
  int unsigned tbl_rank [Depth];
  int unsigned tbl_count;
  int unsigned cache_cap;

  page_req_t  pending_reqs[$];
  page_resp_t expected_resps[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  // live keys, so random traffic hits often
  logic [35:0] live_keys[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int find_page(logic [35:0] key);
    for (int i = 0; i < Depth; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void promote_page(int idx);
    int unsigned r;
    r = tbl_rank[idx];
    for (int i = 0; i < Depth; i++)
      if (tbl_valid[i] && tbl_rank[i] < r) tbl_rank[i]++;
    tbl_rank[idx] = 0;
  endfunction

  function automatic void drop_page(int idx);
    int unsigned r;
    r = tbl_rank[idx];
    tbl_valid[idx] = 1'b0;
    for (int i = 0; i < Depth; i++)
      if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic void fill_slot(ref page_resp_t r, input int idx);
    r.page = tbl_key[idx][31:0];
    r.sectors = tbl_sectors[idx];
    r.content = tbl_content[idx];
    r.dtime = tbl_time[idx];
    r.state = tbl_state[idx];
  endfunction

  // advance the shadow table by one request and return its response
  function automatic page_resp_t cache_access(page_req_t q);
    page_resp_t r;
    logic [35:0] key;
    int idx;
    int slot;
    int unsigned lim;
    r = '0;
    key = {q.sid, q.page};
    idx = (q.op == REQ_EVICT) ? -1 : find_page(key);
    r.hit = (idx >= 0);
    r.status = ST_OK;
    lim = (cache_cap > Depth) ? Depth : cache_cap;
    case (q.op)
      REQ_PROBE: if (idx < 0) r.status = ST_MISS;
      REQ_LOOKUP: begin
        if (idx < 0) r.status = ST_MISS;
        else begin
          promote_page(idx);
          fill_slot(r, idx);
        end
      end
      REQ_INS_CLEAN, REQ_INS_DIRTY: begin
        slot = -1;
        for (int i = Depth - 1; i >= 0; i--)
          if (!tbl_valid[i]) slot = i;
        if (idx >= 0) r.status = ST_DUP;
        else if (tbl_count >= lim || slot < 0) r.status = ST_FULL;
        else begin
          for (int i = 0; i < Depth; i++)
            if (tbl_valid[i]) tbl_rank[i]++;
          tbl_valid[slot] = 1'b1;
          tbl_key[slot] = key;
          tbl_sectors[slot] = q.mask;
          tbl_content[slot] = q.content;
          tbl_time[slot] = q.dtime;
          tbl_state[slot] = (q.op == REQ_INS_CLEAN) ? SLOT_CLEAN : SLOT_DIRTY;
          tbl_rank[slot] = 0;
          tbl_count++;
        end
      end
      REQ_UPDATE: begin
        if (idx < 0) r.status = ST_MISS;
        else begin
          tbl_sectors[idx] = q.mask;
          tbl_content[idx] = q.content;
          tbl_time[idx] = q.dtime;
          tbl_state[idx] = SLOT_DIRTY;
          promote_page(idx);
        end
      end
      REQ_MARK_WB: begin
        if (idx < 0) r.status = ST_MISS;
        else tbl_state[idx] = SLOT_WB;
      end
      REQ_REMOVE: begin
        if (idx < 0) r.status = ST_MISS;
        else drop_page(idx);
      end
      default: begin
        slot = -1;
        if (tbl_count != 0)
          for (int i = 0; i < Depth; i++)
            if (slot < 0 && tbl_valid[i] && tbl_rank[i] == tbl_count - 1) slot = i;
        if (slot < 0) r.status = ST_EMPTY;
        else begin
          fill_slot(r, slot);
          drop_page(slot);
        end
      end
    endcase
    r.occ = tbl_count[8:0];
    return r;
  endfunction

  function automatic page_req_t rand_req(req_t op, bit reuse);
    page_req_t q;
    logic [35:0] k;
    q.op = op;
    q.sid = 4'($urandom_range(0, 15));
    q.page = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
    q.content = {$urandom, $urandom};
    q.dtime = {$urandom, $urandom};
    q.mask = 16'($urandom);
    if (reuse && live_keys.size() > 0) begin
      k = live_keys[$urandom_range(0, live_keys.size() - 1)];
      {q.sid, q.page} = k;
    end
    return q;
  endfunction

  task automatic add_req(page_req_t q);
    if (q.op == REQ_INS_CLEAN || q.op == REQ_INS_DIRTY)
      live_keys.insert(live_keys.size(), {q.sid, q.page});
    if (live_keys.size() > 64) void'(live_keys.pop_front());
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_stall)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_capacity(int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cache_cap = v;
  endtask

  task automatic random_phase(int n);
    int unsigned p;
    req_t op;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      if (p < 30) op = ($urandom_range(0, 1) == 0) ? REQ_INS_CLEAN : REQ_INS_DIRTY;
      else op = req_t'($urandom_range(0, 7));
      add_req(rand_req(op, $urandom_range(0, 99) < 70));
    end
  endtask

  // mismatch reporting
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    page_req_t q;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_resps.insert(expected_resps.size(), cache_access(pending_reqs.pop_front()));
      end
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
          !(in_valid && pending_reqs.size() == 0)) begin
        q = pending_reqs[0];
        in_valid <= 1'b1;
        req_type <= q.op;
        stream_num <= q.sid;
        page_number <= q.page;
        page_content <= q.content;
        data_time <= q.dtime;
        sector_mask <= q.mask;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    page_resp_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected transfer", '0, '0);
        end else begin
          e = expected_resps.pop_front();
          if (status_code !== e.status)
            report_mismatch("status_code", 64'(status_code), 64'(e.status));
          if (found !== e.hit) report_mismatch("found", 64'(found), 64'(e.hit));
          if (slot_page !== e.page)
            report_mismatch("slot_page", 64'(slot_page), 64'(e.page));
          if (slot_sectors !== e.sectors)
            report_mismatch("slot_sectors", 64'(slot_sectors), 64'(e.sectors));
          if (slot_content !== e.content)
            report_mismatch("slot_content", slot_content, e.content);
          if (slot_time !== e.dtime) report_mismatch("slot_time", slot_time, e.dtime);
          if (slot_state !== e.state)
            report_mismatch("slot_state", 64'(slot_state), 64'(e.state));
          if (occupancy !== e.occ)
            report_mismatch("occupancy", 64'(occupancy), 64'(e.occ));
        end
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    page_req_t q;
    errors = 0;
    hold_cycles = 0;
    send_idle_pct = 35;
    recv_idle_pct = 80;
    cache_cap = 256;
    tbl_count = 0;
    for (int i = 0; i < Depth; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_rank[i] = 0;
    end
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    req_type = '0;
    stream_num = '0;
    page_number = '0;
    page_content = '0;
    data_time = '0;
    sector_mask = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table cases, extremes, every operation
    add_req(rand_req(REQ_EVICT, 0));
    q = rand_req(REQ_PROBE, 0); q.sid = 4'hF; q.page = '1; add_req(q);
    q.op = REQ_LOOKUP; add_req(q);
    q.op = REQ_INS_CLEAN; q.content = '1; q.dtime = '1; q.mask = '1; add_req(q);
    q.op = REQ_INS_DIRTY; add_req(q);
    q.op = REQ_PROBE; add_req(q);
    q.op = REQ_LOOKUP; add_req(q);
    q = rand_req(REQ_INS_DIRTY, 0); q.sid = 0; q.page = 0; q.content = 0; q.dtime = 0;
    q.mask = 0; add_req(q);
    q.op = REQ_UPDATE; q.content = '1; add_req(q);
    q.op = REQ_MARK_WB; add_req(q);
    q.op = REQ_LOOKUP; add_req(q);
    q = rand_req(REQ_UPDATE, 0); q.page = 32'h8000_0000; add_req(q);
    q.op = REQ_MARK_WB; add_req(q);
    q.op = REQ_REMOVE; add_req(q);
    q = rand_req(REQ_REMOVE, 0); q.sid = 4'hF; q.page = '1; add_req(q);
    add_req(rand_req(REQ_EVICT, 0));
    add_req(rand_req(REQ_EVICT, 0));
    add_req(rand_req(REQ_EVICT, 0));
    wait_drained();

    // capacity one: full table and lowered capacity
    set_capacity(1);
    add_req(rand_req(REQ_INS_CLEAN, 0));
    add_req(rand_req(REQ_INS_DIRTY, 0));
    add_req(rand_req(REQ_INS_CLEAN, 0));
    wait_drained();
    set_capacity(0);
    add_req(rand_req(REQ_INS_CLEAN, 0));
    add_req(rand_req(REQ_EVICT, 0));
    add_req(rand_req(REQ_INS_DIRTY, 0));
    wait_drained();

    // random phases over several capacities
    set_capacity(4);
    random_phase(300);
    // long receiver hold so the block backs up
    hold_cycles = 3000;
    wait_drained();

    set_capacity(511);
    send_idle_pct = 80;
    recv_idle_pct = 35;
    random_phase(350);
    wait_drained();

    set_capacity(16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(300);
    wait_drained();

    // fill to full depth, then a short random phase
    set_capacity(256);
    for (int k = 0; k < 260; k++) begin
      q = rand_req(REQ_INS_DIRTY, 0);
      q.page = k;
      add_req(q);
    end
    random_phase(40);
    wait_drained();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
